>>> rtl/core/tilemap_corner_autotile_core_macros.svh
// tilemap_corner_autotile_core_macros.svh
// Assertion helpers for the corner autotile core; modules expect i_clk and i_rst_n in scope.
// The bodies are empty when SYNTHESIS is defined.
`ifndef TILEMAP_CORNER_AUTOTILE_CORE_MACROS_SVH
`define TILEMAP_CORNER_AUTOTILE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TMCA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tmca: same-cycle check failed");
`define TMCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tmca: next-cycle check failed");
`else
`define TMCA_ASSERT_IMPL(lbl, ante, cons)
`define TMCA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/tmca_pkg.sv
// tmca_pkg.sv
// Shared widths, register indexes and structs of the corner autotile core.
// No dependencies.
package tmca_pkg;
    localparam int MAX_HEIGHT_DEF = 32;
    localparam int TYPE_BITS_DEF  = 4;

    localparam int TILE_W   = 4;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 5;
    localparam int ID_W     = 16;
    localparam int LAYER_W  = 4;
    localparam int MAPW_W   = 11;
    localparam int MAPH_W   = 6;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 88;

    localparam logic [MAPW_W-1:0] MAPW_RST = 11'd1024;
    localparam logic [MAPH_W-1:0] MAPH_RST = 6'd32;

    typedef enum logic [2:0] {
        REG_CHECK_TYPE   = 3'd0,
        REG_DEFAULT_TYPE = 3'd1,
        REG_BASE_TILE_ID = 3'd2,
        REG_FILL_MODE    = 3'd3,
        REG_MAP_WIDTH    = 3'd4,
        REG_MAP_HEIGHT   = 3'd5,
        REG_TARGET_LAYER = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [TILE_W-1:0]  check_type;
        logic [TILE_W-1:0]  default_type;
        logic [ID_W-1:0]    base_tile_id;
        logic               fill_mode;
        logic [MAPW_W-1:0]  map_width;
        logic [MAPH_W-1:0]  map_height;
        logic [LAYER_W-1:0] target_layer;
    } t_cfg;

    // column job handed from the assembler to the emitter
    typedef struct packed {
        logic             two_col;   // end-of-map flush: a second column follows
        logic [COL_W-1:0] col;
    } t_job_ctl;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [ID_W-1:0]    id_top_left;
        logic [ID_W-1:0]    id_top_right;
        logic [ID_W-1:0]    id_bottom_left;
        logic [ID_W-1:0]    id_bottom_right;
        logic [LAYER_W-1:0] layer;
        logic               last;
    } t_result;
endpackage

>>> rtl/core/tmca_cfg.sv
// tmca_cfg.sv
// APB register file of the corner autotile core.
// Depends on tmca_pkg.
module tmca_cfg #(
    parameter int TYPE_BITS = tmca_pkg::TYPE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmca_pkg::APB_AW-1:0] paddr,
    input  logic [tmca_pkg::APB_DW-1:0] pwdata,
    output logic [tmca_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output tmca_pkg::t_cfg              o_cfg,
    output logic                        o_default_mis
);
    import tmca_pkg::*;

    localparam logic [TILE_W-1:0] TMASK = TILE_W'((1 << TYPE_BITS) - 1);

    logic [TILE_W-1:0]  r_check_type;
    logic [TILE_W-1:0]  r_default_type;
    logic [ID_W-1:0]    r_base_tile_id;
    logic               r_fill_mode;
    logic [MAPW_W-1:0]  r_map_width;
    logic [MAPH_W-1:0]  r_map_height;
    logic [LAYER_W-1:0] r_target_layer;
    logic               wr_en;
    t_reg_idx           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_type   <= '0;
            r_default_type <= '0;
            r_base_tile_id <= '0;
            r_fill_mode    <= 1'b0;
            r_map_width    <= MAPW_RST;
            r_map_height   <= MAPH_RST;
            r_target_layer <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_CHECK_TYPE:   r_check_type   <= pwdata[TILE_W-1:0];
                REG_DEFAULT_TYPE: r_default_type <= pwdata[TILE_W-1:0];
                REG_BASE_TILE_ID: r_base_tile_id <= pwdata[ID_W-1:0];
                REG_FILL_MODE:    r_fill_mode    <= pwdata[0];
                REG_MAP_WIDTH:    r_map_width    <= pwdata[MAPW_W-1:0];
                REG_MAP_HEIGHT:   r_map_height   <= pwdata[MAPH_W-1:0];
                REG_TARGET_LAYER: r_target_layer <= pwdata[LAYER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_CHECK_TYPE:   prdata = APB_DW'(r_check_type);
            REG_DEFAULT_TYPE: prdata = APB_DW'(r_default_type);
            REG_BASE_TILE_ID: prdata = APB_DW'(r_base_tile_id);
            REG_FILL_MODE:    prdata = APB_DW'(r_fill_mode);
            REG_MAP_WIDTH:    prdata = APB_DW'(r_map_width);
            REG_MAP_HEIGHT:   prdata = APB_DW'(r_map_height);
            REG_TARGET_LAYER: prdata = APB_DW'(r_target_layer);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.check_type   = r_check_type;
    assign o_cfg.default_type = r_default_type;
    assign o_cfg.base_tile_id = r_base_tile_id;
    assign o_cfg.fill_mode    = r_fill_mode;
    assign o_cfg.map_width    = r_map_width;
    assign o_cfg.map_height   = r_map_height;
    assign o_cfg.target_layer = r_target_layer;

    // off-map neighbors mismatch when the default type differs from the checked one
    assign o_default_mis = (r_default_type & TMASK) != (r_check_type & TMASK);
endmodule

>>> rtl/core/tmca_column.sv
// tmca_column.sv
// Column assembler: collects match bits of the arriving column and issues column jobs.
// Depends on tmca_pkg and the assertion macros header.
`include "tilemap_corner_autotile_core_macros.svh"
module tmca_column #(
    parameter int MAX_HEIGHT = tmca_pkg::MAX_HEIGHT_DEF,
    parameter int TYPE_BITS  = tmca_pkg::TYPE_BITS_DEF,
    localparam int RIDX_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int CNT_W     = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tmca_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [tmca_pkg::TILE_W-1:0] i_tile,
    input  logic                        i_end,
    output logic                        o_job_valid,
    input  logic                        i_job_take,
    output tmca_pkg::t_job_ctl          o_job_ctl,
    output logic [MAX_HEIGHT-1:0]       o_job_l,
    output logic [MAX_HEIGHT-1:0]       o_job_c,
    output logic [MAX_HEIGHT-1:0]       o_job_r,
    output logic [CNT_W-1:0]            o_job_lr,
    output logic [CNT_W-1:0]            o_job_cr,
    output logic [CNT_W-1:0]            o_job_rr,
    output logic [CNT_W-1:0]            o_job_nr
);
    import tmca_pkg::*;

    localparam logic [TILE_W-1:0] TMASK = TILE_W'((1 << TYPE_BITS) - 1);

    logic [MAX_HEIGHT-1:0] r_prev, r_cur, r_new;
    logic [CNT_W-1:0]      r_prev_rows, r_cur_rows;
    logic [COL_W-1:0]      r_col_cnt;
    logic [RIDX_W-1:0]     r_row;
    logic                  r_job_valid;

    t_job_ctl              r_job_ctl, n_job_ctl;
    logic [MAX_HEIGHT-1:0] r_job_l, r_job_c, r_job_r, n_job_l, n_job_c, n_job_r;
    logic [CNT_W-1:0]      r_job_lr, r_job_cr, r_job_rr, r_job_nr;
    logic [CNT_W-1:0]      n_job_lr, n_job_cr, n_job_rr;

    logic [CNT_W-1:0]      h_eff, h_m1, nr;
    logic [MAPW_W-1:0]     w_eff;
    logic [RIDX_W-1:0]     row_c;
    logic [COL_W-1:0]      prevcol;
    logic [MAX_HEIGHT-1:0] nv;
    logic                  acc, col_done, match, right_on, job_load;

    always_comb begin
        if (i_cfg.map_height == '0) begin
            h_eff = CNT_W'(1);
        end else if (i_cfg.map_height > MAPH_W'(MAX_HEIGHT)) begin
            h_eff = CNT_W'(MAX_HEIGHT);
        end else begin
            h_eff = CNT_W'(i_cfg.map_height);
        end
    end

    assign w_eff    = (i_cfg.map_width == '0) ? MAPW_W'(1) : i_cfg.map_width;
    assign h_m1     = h_eff - CNT_W'(1);
    // row counter can sit past a height that was lowered while idle
    assign row_c    = (CNT_W'(r_row) > h_m1) ? RIDX_W'(h_m1) : r_row;
    assign nr       = CNT_W'(row_c) + CNT_W'(1);
    assign col_done = (CNT_W'(row_c) == h_m1);
    assign match    = (i_tile & TMASK) == (i_cfg.check_type & TMASK);
    assign prevcol  = r_col_cnt - COL_W'(1);
    assign right_on = (MAPW_W'(prevcol) + MAPW_W'(1)) < w_eff;

    always_comb begin
        nv        = r_new;
        nv[row_c] = match;
    end

    assign o_ready  = !r_job_valid || i_job_take;
    assign acc      = i_valid && o_ready;
    assign job_load = acc && (i_end || (col_done && (r_cur_rows != '0)));

    always_comb begin
        n_job_ctl.two_col = 1'b0;
        n_job_ctl.col     = prevcol;
        n_job_l           = r_prev;
        n_job_lr          = r_prev_rows;
        n_job_c           = r_cur;
        n_job_cr          = r_cur_rows;
        n_job_r           = nv;
        n_job_rr          = right_on ? h_eff : '0;
        if (i_end) begin
            n_job_rr = right_on ? nr : '0;
            if (r_cur_rows != '0) begin
                n_job_ctl.two_col = 1'b1;
            end else begin
                // only the partial column is pending
                n_job_ctl.col = r_col_cnt;
                n_job_l       = r_cur;
                n_job_lr      = r_cur_rows;
                n_job_c       = nv;
                n_job_cr      = nr;
                n_job_rr      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_prev      <= '0;
            r_cur       <= '0;
            r_new       <= '0;
            r_prev_rows <= '0;
            r_cur_rows  <= '0;
            r_col_cnt   <= '0;
            r_row       <= '0;
        end else begin
            if (job_load) begin
                r_job_valid <= 1'b1;
            end else if (i_job_take) begin
                r_job_valid <= 1'b0;
            end
            if (acc) begin
                if (i_end) begin
                    r_prev      <= '0;
                    r_cur       <= '0;
                    r_new       <= '0;
                    r_prev_rows <= '0;
                    r_cur_rows  <= '0;
                    r_col_cnt   <= '0;
                    r_row       <= '0;
                end else if (col_done) begin
                    r_prev      <= r_cur;
                    r_prev_rows <= r_cur_rows;
                    r_cur       <= nv;
                    r_cur_rows  <= h_eff;
                    r_new       <= '0;
                    r_col_cnt   <= r_col_cnt + COL_W'(1);
                    r_row       <= '0;
                end else begin
                    r_new <= nv;
                    r_row <= row_c + RIDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_load) begin
            r_job_ctl <= n_job_ctl;
            r_job_l   <= n_job_l;
            r_job_c   <= n_job_c;
            r_job_r   <= n_job_r;
            r_job_lr  <= n_job_lr;
            r_job_cr  <= n_job_cr;
            r_job_rr  <= n_job_rr;
            r_job_nr  <= nr;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job_ctl   = r_job_ctl;
    assign o_job_l     = r_job_l;
    assign o_job_c     = r_job_c;
    assign o_job_r     = r_job_r;
    assign o_job_lr    = r_job_lr;
    assign o_job_cr    = r_job_cr;
    assign o_job_rr    = r_job_rr;
    assign o_job_nr    = r_job_nr;

    `TMCA_ASSERT_NEXT(a_end_clears, acc && i_end,
                      r_col_cnt == '0 && r_row == '0 && r_cur_rows == '0)
    `TMCA_ASSERT_NEXT(a_col_wraps_row, acc && !i_end && col_done, r_row == '0)
    `TMCA_ASSERT_IMPL(a_flush_job_rows, r_job_valid && r_job_ctl.two_col, r_job_cr != '0)
endmodule

>>> rtl/core/tmca_emit.sv
// tmca_emit.sv
// Corner emitter: walks the matching rows of a column job and computes four corner ids.
// Depends on tmca_pkg and the assertion macros header.
`include "tilemap_corner_autotile_core_macros.svh"
module tmca_emit #(
    parameter int MAX_HEIGHT = tmca_pkg::MAX_HEIGHT_DEF,
    localparam int RIDX_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int CNT_W     = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tmca_pkg::t_cfg        i_cfg,
    input  logic                  i_default_mis,
    input  logic                  i_job_valid,
    output logic                  o_job_take,
    input  tmca_pkg::t_job_ctl    i_job_ctl,
    input  logic [MAX_HEIGHT-1:0] i_job_l,
    input  logic [MAX_HEIGHT-1:0] i_job_c,
    input  logic [MAX_HEIGHT-1:0] i_job_r,
    input  logic [CNT_W-1:0]      i_job_lr,
    input  logic [CNT_W-1:0]      i_job_cr,
    input  logic [CNT_W-1:0]      i_job_rr,
    input  logic [CNT_W-1:0]      i_job_nr,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tmca_pkg::t_result     o_res
);
    import tmca_pkg::*;

    // status of one neighbor: {off map, on map and mismatching}
    function automatic logic [1:0] look(input logic [MAX_HEIGHT-1:0] v,
                                        input logic [CNT_W-1:0] n,
                                        input logic [RIDX_W:0] p,
                                        input logic under);
        logic off;
        off = under || (p >= (RIDX_W+1)'(n));
        return {off, !off && !v[p[RIDX_W-1:0]]};
    endfunction

    function automatic logic [ID_W-1:0] corner(input logic [1:0] hs, input logic [1:0] vs,
                                               input logic [1:0] ds, input logic dm,
                                               input logic [ID_W-1:0] base);
        logic hm, vm, dg;
        hm = hs[1] ? dm : hs[0];
        vm = vs[1] ? dm : vs[0];
        dg = !hm && !vm && ds[0];
        return base + ID_W'({dg, hm, vm});
    endfunction

    function automatic logic [MAX_HEIGHT-1:0] row_mask(input logic [CNT_W-1:0] n);
        logic [MAX_HEIGHT-1:0] m;
        for (int i = 0; i < MAX_HEIGHT; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    logic                  r_act, r_ovalid, r_two;
    logic [MAX_HEIGHT-1:0] r_l, r_c, r_r, r_mask, r_mask_b;
    logic [CNT_W-1:0]      r_lr, r_cr, r_rr, r_nr;
    logic [COL_W-1:0]      r_col;
    t_result               r_res;

    logic                  out_free, step, has, more_b, fin, fire;
    logic [MAX_HEIGHT-1:0] low, rest;
    logic [RIDX_W-1:0]     j;
    logic [RIDX_W:0]       pj, pu, pd;
    logic                  at_top;
    logic [1:0]            lh, rh, up, dn;
    logic [ID_W-1:0]       id_tl, id_tr, id_bl, id_br;

    assign out_free = !r_ovalid || i_ready;
    assign step     = r_act && out_free;
    assign has      = r_mask != '0;
    assign low      = r_mask & (~r_mask + MAX_HEIGHT'(1));
    assign rest     = r_mask & ~low;
    assign more_b   = r_two && (r_mask_b != '0);
    assign fin      = (rest == '0) && !more_b;
    assign fire     = step && has;
    assign o_job_take = i_job_valid && (!r_act || (step && fin));

    always_comb begin
        j = '0;
        for (int i = MAX_HEIGHT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                j = RIDX_W'(i);
            end
        end
    end

    assign pj     = {1'b0, j};
    assign pu     = pj - (RIDX_W+1)'(1);
    assign pd     = pj + (RIDX_W+1)'(1);
    assign at_top = (j == '0);

    assign lh = look(r_l, r_lr, pj, 1'b0);
    assign rh = look(r_r, r_rr, pj, 1'b0);
    assign up = look(r_c, r_cr, pu, at_top);
    assign dn = look(r_c, r_cr, pd, 1'b0);

    always_comb begin
        if (i_cfg.fill_mode) begin
            id_tl = corner(lh, up, look(r_l, r_lr, pu, at_top), i_default_mis,
                           i_cfg.base_tile_id);
            id_tr = corner(rh, up, look(r_r, r_rr, pu, at_top), i_default_mis,
                           i_cfg.base_tile_id);
            id_bl = corner(lh, dn, look(r_l, r_lr, pd, 1'b0), i_default_mis,
                           i_cfg.base_tile_id);
            id_br = corner(rh, dn, look(r_r, r_rr, pd, 1'b0), i_default_mis,
                           i_cfg.base_tile_id);
        end else begin
            id_tl = i_cfg.base_tile_id;
            id_tr = i_cfg.base_tile_id;
            id_bl = i_cfg.base_tile_id;
            id_br = i_cfg.base_tile_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_free) begin
                r_ovalid <= fire;
            end
            if (o_job_take) begin
                r_act <= 1'b1;
            end else if (step && fin) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_l      <= i_job_l;
            r_c      <= i_job_c;
            r_r      <= i_job_r;
            r_lr     <= i_job_lr;
            r_cr     <= i_job_cr;
            r_rr     <= i_job_rr;
            r_nr     <= i_job_nr;
            r_col    <= i_job_ctl.col;
            r_two    <= i_job_ctl.two_col;
            r_mask   <= i_job_c & row_mask(i_job_cr);
            r_mask_b <= i_job_r & row_mask(i_job_nr);
        end else if (step) begin
            if (rest == '0 && more_b) begin
                // flush: the partial column becomes the center, nothing to its right
                r_l    <= r_c;
                r_lr   <= r_cr;
                r_c    <= r_r;
                r_cr   <= r_nr;
                r_rr   <= '0;
                r_col  <= r_col + COL_W'(1);
                r_two  <= 1'b0;
                r_mask <= r_mask_b;
            end else begin
                r_mask <= rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res.col             <= r_col;
            r_res.row             <= ROW_W'(j);
            r_res.id_top_left     <= id_tl;
            r_res.id_top_right    <= id_tr;
            r_res.id_bottom_left  <= id_bl;
            r_res.id_bottom_right <= id_br;
            r_res.layer           <= i_cfg.target_layer;
            r_res.last            <= fin;
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    `TMCA_ASSERT_IMPL(a_mask_in_rows, r_act, (r_mask & ~row_mask(r_cr)) == '0)
    `TMCA_ASSERT_IMPL(a_flush_center_rows, r_act && r_two, r_cr != '0)
    `TMCA_ASSERT_NEXT(a_last_ends_job, fire && fin && !i_job_valid, !r_act)
endmodule

>>> rtl/core/tilemap_corner_autotile_core.sv
// tilemap_corner_autotile_core.sv
// Top level of the corner autotile core: APB registers, column assembler, corner emitter.
// Depends on tmca_pkg, tmca_cfg, tmca_column, tmca_emit.
//
//  channel   | direction | word
//  ----------+-----------+-------------------------------------------------------
//  s_axis    | in        | one tile type per word, column-major; tlast ends the map
//  m_axis    | out       | one filled tile per word: position, four corner ids, layer
//  apb       | in/out    | seven config registers at byte offsets 0x00..0x18
//
// One tile word is taken per cycle. A column's results leave once the column to its right
// has fully arrived: one word per matching row, and none for a column with no match;
// a second finished column waits in a one-job slot, and s_axis stalls only while that slot
// is full. End of map drains any pending complete column and the partial one back to back.
// Results of a column pass the job slot, the emitter's job registers and its output register.
// Reset is synchronous.
module tilemap_corner_autotile_core #(
    parameter int MAX_HEIGHT = tmca_pkg::MAX_HEIGHT_DEF,
    parameter int TYPE_BITS  = tmca_pkg::TYPE_BITS_DEF,
    localparam int CNT_W     = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tmca_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [3:0] tile_type
    input  logic                           s_axis_tlast,   // end_of_map
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [9:0] col, [14:10] row, [30:15] id_top_left, [46:31] id_top_right,
    // [62:47] id_bottom_left, [78:63] id_bottom_right, [82:79] layer
    output logic [tmca_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,   // last
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tmca_pkg::APB_AW-1:0]    paddr,
    input  logic [tmca_pkg::APB_DW-1:0]    pwdata,
    output logic [tmca_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import tmca_pkg::*;

    t_cfg                  cfg;
    logic                  default_mis;
    logic                  job_valid, job_take;
    t_job_ctl              job_ctl;
    logic [MAX_HEIGHT-1:0] job_l, job_c, job_r;
    logic [CNT_W-1:0]      job_lr, job_cr, job_rr, job_nr;
    t_result               res;

    tmca_cfg #(
        .TYPE_BITS (TYPE_BITS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_cfg         (cfg),
        .o_default_mis (default_mis)
    );

    tmca_column #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .TYPE_BITS  (TYPE_BITS)
    ) u_column (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_tile      (s_axis_tdata[TILE_W-1:0]),
        .i_end       (s_axis_tlast),
        .o_job_valid (job_valid),
        .i_job_take  (job_take),
        .o_job_ctl   (job_ctl),
        .o_job_l     (job_l),
        .o_job_c     (job_c),
        .o_job_r     (job_r),
        .o_job_lr    (job_lr),
        .o_job_cr    (job_cr),
        .o_job_rr    (job_rr),
        .o_job_nr    (job_nr)
    );

    tmca_emit #(
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_default_mis (default_mis),
        .i_job_valid   (job_valid),
        .o_job_take    (job_take),
        .i_job_ctl     (job_ctl),
        .i_job_l       (job_l),
        .i_job_c       (job_c),
        .i_job_r       (job_r),
        .i_job_lr      (job_lr),
        .i_job_cr      (job_cr),
        .i_job_rr      (job_rr),
        .i_job_nr      (job_nr),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_res         (res)
    );

    assign m_axis_tdata = {5'b0, res.layer, res.id_bottom_right, res.id_bottom_left,
                           res.id_top_right, res.id_top_left, res.row, res.col};
    assign m_axis_tlast = res.last;
endmodule

>>> tb/sv/tmca_checker.sv
// tmca_checker.sv
// Scoreboard for the corner autotile core. It follows APB writes, predicts the filled-tile
// words from accepted tile words and compares them with m_axis. Depends on tmca_pkg.
module tmca_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [tmca_pkg::S_TDATA_W-1:0] s_axis_tdata,    // [3:0] tile_type
    input  logic                           s_axis_tlast,    // end_of_map
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [9:0] col, [14:10] row, [30:15] id_top_left, [46:31] id_top_right,
    // [62:47] id_bottom_left, [78:63] id_bottom_right, [82:79] layer
    input  logic [tmca_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                           m_axis_tlast,    // last
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tmca_pkg::APB_AW-1:0]    paddr,
    input  logic [tmca_pkg::APB_DW-1:0]    pwdata,
    input  logic                           pready,
    output int                             o_fail_count,
    output int                             o_pending
);
    import tmca_pkg::*;

    localparam int MAXH = MAX_HEIGHT_DEF;

    typedef enum logic [1:0] {NB_MATCH, NB_MISS, NB_OFF} t_nbr;

    t_cfg             regs;
    logic [MAXH-1:0]  older_bits;
    logic [MAXH-1:0]  newer_bits;
    logic [MAXH-1:0]  arriving_bits;
    int               older_rows;
    int               newer_rows;
    logic [COL_W-1:0] col_cnt;
    logic [ROW_W-1:0] row_cnt;
    t_result          expected_tiles[$];
    int               mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void restart_scan();
        older_bits    = '0;
        newer_bits    = '0;
        arriving_bits = '0;
        older_rows    = 0;
        newer_rows    = 0;
        col_cnt       = '0;
        row_cnt       = '0;
    endfunction

    function automatic t_nbr probe(logic [MAXH-1:0] bits, int rows, int r);
        if (r < 0 || r >= rows || r >= MAXH)
            return NB_OFF;
        return bits[r] ? NB_MATCH : NB_MISS;
    endfunction

    function automatic logic [ID_W-1:0] corner_id(t_nbr h, t_nbr v, t_nbr d, logic off_miss);
        logic            hm;
        logic            vm;
        logic [ID_W-1:0] id;
        hm = (h == NB_OFF) ? off_miss : (h == NB_MISS);
        vm = (v == NB_OFF) ? off_miss : (v == NB_MISS);
        id = regs.base_tile_id;
        if (hm)
            id = id + 16'd2;
        if (vm)
            id = id + 16'd1;
        // diagonal only counts when it is on the map
        if (!hm && !vm && d == NB_MISS)
            id = id + 16'd4;
        return id;
    endfunction

    // queue one word per matching row of the middle column; returns the count
    function automatic int queue_column(logic [MAXH-1:0] lb, int lr, logic [MAXH-1:0] cb,
                                        int cr, logic [MAXH-1:0] rb, int rr, int colidx);
        int      n;
        logic    off_miss;
        t_nbr    lh;
        t_nbr    rh;
        t_nbr    up;
        t_nbr    dn;
        t_result w;
        n = 0;
        off_miss = (regs.default_type != regs.check_type);
        for (int j = 0; j < cr && j < MAXH; j++) begin
            if (cb[j]) begin
                w.col = COL_W'(colidx);
                w.row = ROW_W'(j);
                if (regs.fill_mode) begin
                    lh = probe(lb, lr, j);
                    rh = probe(rb, rr, j);
                    up = probe(cb, cr, j - 1);
                    dn = probe(cb, cr, j + 1);
                    w.id_top_left     = corner_id(lh, up, probe(lb, lr, j - 1), off_miss);
                    w.id_top_right    = corner_id(rh, up, probe(rb, rr, j - 1), off_miss);
                    w.id_bottom_left  = corner_id(lh, dn, probe(lb, lr, j + 1), off_miss);
                    w.id_bottom_right = corner_id(rh, dn, probe(rb, rr, j + 1), off_miss);
                end else begin
                    w.id_top_left     = regs.base_tile_id;
                    w.id_top_right    = regs.base_tile_id;
                    w.id_bottom_left  = regs.base_tile_id;
                    w.id_bottom_right = regs.base_tile_id;
                end
                w.layer = regs.target_layer;
                w.last  = 1'b0;
                expected_tiles.push_back(w);
                n++;
            end
        end
        return n;
    endfunction

    function automatic void advance_map(logic [TILE_W-1:0] tile, logic eom);
        int      h;
        int      w;
        int      r;
        int      prevcol;
        int      n;
        t_result tail;
        h = int'(regs.map_height);
        if (h == 0)
            h = 1;
        if (h > MAXH)
            h = MAXH;
        w = (regs.map_width == '0) ? 1 : int'(regs.map_width);
        r = int'(row_cnt);
        if (r > h - 1)
            r = h - 1;
        prevcol = (int'(col_cnt) + 1023) % 1024;
        n = 0;
        arriving_bits[r] = (tile == regs.check_type);
        if (eom) begin
            // flush: pending complete column, then the partial one with nothing to its right
            if (newer_rows != 0)
                n += queue_column(older_bits, older_rows, newer_bits, newer_rows,
                                  arriving_bits, (prevcol + 1 < w) ? r + 1 : 0, prevcol);
            n += queue_column(newer_bits, newer_rows, arriving_bits, r + 1,
                              arriving_bits, 0, int'(col_cnt));
            restart_scan();
        end else if (r + 1 >= h) begin
            if (newer_rows != 0)
                n += queue_column(older_bits, older_rows, newer_bits, newer_rows,
                                  arriving_bits, (prevcol + 1 < w) ? h : 0, prevcol);
            older_bits    = newer_bits;
            older_rows    = newer_rows;
            newer_bits    = arriving_bits;
            newer_rows    = h;
            arriving_bits = '0;
            col_cnt       = col_cnt + 1'b1;
            row_cnt       = '0;
        end else begin
            row_cnt = ROW_W'(r + 1);
        end
        if (n > 0) begin
            tail = expected_tiles.pop_back();
            tail.last = 1'b1;
            expected_tiles.push_back(tail);
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input int got, input int want,
                                 input t_result w);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d (col %0d row %0d)",
                                      name, got, want, w.col, w.row));
    endtask

    task automatic check_word();
        t_result got;
        t_result want;
        got.col             = m_axis_tdata[9:0];
        got.row             = m_axis_tdata[14:10];
        got.id_top_left     = m_axis_tdata[30:15];
        got.id_top_right    = m_axis_tdata[46:31];
        got.id_bottom_left  = m_axis_tdata[62:47];
        got.id_bottom_right = m_axis_tdata[78:63];
        got.layer           = m_axis_tdata[82:79];
        got.last            = m_axis_tlast;
        if (expected_tiles.size() == 0) begin
            report_mismatch($sformatf("word with nothing expected: col %0d row %0d",
                                      got.col, got.row));
        end else begin
            want = expected_tiles.pop_front();
            compare_field("col", got.col, want.col, want);
            compare_field("row", got.row, want.row, want);
            compare_field("id_top_left", got.id_top_left, want.id_top_left, want);
            compare_field("id_top_right", got.id_top_right, want.id_top_right, want);
            compare_field("id_bottom_left", got.id_bottom_left, want.id_bottom_left, want);
            compare_field("id_bottom_right", got.id_bottom_right, want.id_bottom_right, want);
            compare_field("layer", got.layer, want.layer, want);
            compare_field("last", got.last, want.last, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_scan();
            regs = '0;
            regs.map_width  = MAPW_RST;
            regs.map_height = MAPH_RST;
            expected_tiles.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_CHECK_TYPE:   regs.check_type   = pwdata[TILE_W-1:0];
                    REG_DEFAULT_TYPE: regs.default_type = pwdata[TILE_W-1:0];
                    REG_BASE_TILE_ID: regs.base_tile_id = pwdata[ID_W-1:0];
                    REG_FILL_MODE:    regs.fill_mode    = pwdata[0];
                    REG_MAP_WIDTH:    regs.map_width    = pwdata[MAPW_W-1:0];
                    REG_MAP_HEIGHT:   regs.map_height   = pwdata[MAPH_W-1:0];
                    REG_TARGET_LAYER: regs.target_layer = pwdata[LAYER_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_map(s_axis_tdata[TILE_W-1:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                check_word();
        end
        o_pending <= expected_tiles.size();
    end
endmodule

>>> tb/sv/tb_top.sv
// tb_top.sv
// Stimulus and verdict for the corner autotile core: reset, APB register setup, tile maps
// streamed with random gaps and back-pressure. Depends on tmca_pkg and tmca_checker.
module tb_top;
    import tmca_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE       = 16;
    localparam int RANDOM_ITEMS = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;     // [3:0] tile_type
    logic                 s_axis_tlast;     // end_of_map
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // [9:0] col, [14:10] row, [30:15] id_top_left, [46:31] id_top_right,
    // [62:47] id_bottom_left, [78:63] id_bottom_right, [82:79] layer
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;     // last
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int                   fail_count;
    int                   pending;
    int                   cycles = 0;
    bit                   calm;
    int                   gap_level;
    int                   stall_level;
    logic [TILE_W-1:0]    map_tiles[$];

    tilemap_corner_autotile_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tmca_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // back-pressure on the result side, in bursts
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 7) < stall_level) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(REG_CHECK_TYPE, APB_DW'(c.check_type));
        write_reg(REG_DEFAULT_TYPE, APB_DW'(c.default_type));
        write_reg(REG_BASE_TILE_ID, APB_DW'(c.base_tile_id));
        write_reg(REG_FILL_MODE, APB_DW'(c.fill_mode));
        write_reg(REG_MAP_WIDTH, APB_DW'(c.map_width));
        write_reg(REG_MAP_HEIGHT, APB_DW'(c.map_height));
        write_reg(REG_TARGET_LAYER, APB_DW'(c.target_layer));
    endtask

    // streams map_tiles, tlast on the final word
    task automatic send_map();
        for (int k = 0; k < map_tiles.size(); k++) begin
            if (!calm && $urandom_range(0, 7) < gap_level) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {{(S_TDATA_W - TILE_W){1'b0}}, map_tiles[k]};
            s_axis_tlast  <= (k == map_tiles.size() - 1);
            do @(posedge i_clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
    endtask

    // all results in, then room for columns that produce no word
    task automatic settle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [TILE_W-1:0] pick_tile(logic [TILE_W-1:0] match);
        return ($urandom_range(0, 9) < 6) ? match : TILE_W'($urandom_range(0, 15));
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.check_type   = TILE_W'($urandom_range(0, 15));
        c.default_type = $urandom_range(0, 1) ? c.check_type : TILE_W'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0:       c.base_tile_id = 16'd0;
            1:       c.base_tile_id = 16'd65528;
            2:       c.base_tile_id = 16'hFFFF;
            default: c.base_tile_id = ID_W'($urandom_range(0, 65535));
        endcase
        c.fill_mode = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) < 7) begin
            c.map_width = MAPW_W'($urandom_range(1, 6));
        end else begin
            case ($urandom_range(0, 4))
                0:       c.map_width = 11'd0;
                1:       c.map_width = 11'd1024;
                2:       c.map_width = 11'd2047;
                3:       c.map_width = 11'd1023;
                default: c.map_width = MAPW_W'($urandom_range(7, 40));
            endcase
        end
        if ($urandom_range(0, 9) < 7) begin
            c.map_height = MAPH_W'($urandom_range(1, 6));
        end else begin
            case ($urandom_range(0, 4))
                0:       c.map_height = 6'd0;
                1:       c.map_height = 6'd31;
                2:       c.map_height = 6'd32;
                3:       c.map_height = 6'd33;
                default: c.map_height = 6'd63;
            endcase
        end
        c.target_layer = LAYER_W'($urandom_range(0, 15));
        return c;
    endfunction

    initial begin
        t_cfg c;
        int   sent;
        int   we;
        int   he;
        int   full;
        int   n;
        int   kind;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        gap_level     = 2;
        stall_level   = 2;
        sent          = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register values after reset, early end of a tall column
        map_tiles = '{4'd0, 4'd9, 4'd0};
        send_map();
        settle();

        // 3x3 map, off-map mismatching, ids wrap past 0xFFFF
        c = '{4'd15, 4'd0, 16'hFFFF, 1'b1, 11'd3, 6'd3, 4'd15};
        program_regs(c);
        map_tiles = '{4'd15, 4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 4'd15, 4'd15, 4'd15};
        send_map();
        settle();

        // zero width and height act as one, simple fill
        c = '{4'd0, 4'd5, 16'd0, 1'b0, 11'd0, 6'd0, 4'd0};
        program_regs(c);
        map_tiles = '{4'd0, 4'd0, 4'd7};
        send_map();
        settle();

        // oversize width and height, partial column flushed
        c = '{4'd3, 4'd3, 16'd100, 1'b1, 11'd2047, 6'd63, 4'd5};
        program_regs(c);
        map_tiles = '{4'd3, 4'd3, 4'd8, 4'd3, 4'd3};
        send_map();
        settle();

        // pending complete column plus a partial one at end of map
        c = '{4'd9, 4'd9, 16'd65528, 1'b1, 11'd2, 6'd4, 4'd1};
        program_regs(c);
        map_tiles = '{4'd9, 4'd2, 4'd9, 4'd9, 4'd9, 4'd9};
        send_map();
        settle();

        while (sent < RANDOM_ITEMS) begin
            calm        = (sent >= RANDOM_ITEMS - 60);
            gap_level   = calm ? 0 : $urandom_range(0, 4);
            stall_level = calm ? 0 : $urandom_range(0, 4);
            c = random_cfg();
            program_regs(c);
            we = (c.map_width == '0) ? 1 : int'(c.map_width);
            he = int'(c.map_height);
            if (he == 0)
                he = 1;
            if (he > MAX_HEIGHT_DEF)
                he = MAX_HEIGHT_DEF;
            full = we * he;
            kind = $urandom_range(0, 9);
            if (kind <= 5)
                n = (full <= 96) ? full : $urandom_range(1, 96);
            else if (kind <= 7)
                n = $urandom_range(1, (full < 96) ? full : 96);
            else if (kind == 8)
                n = ((full <= 96) ? full : 96) + $urandom_range(1, 2 * he);
            else
                n = 1;
            map_tiles.delete();
            repeat (n) map_tiles.push_back(pick_tile(c.check_type));
            send_map();
            settle();
            sent += n;
        end

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
